/* sv/alct_pkg.sv */
// alct_pkg: shared types, widths and codes of the alarm counter tick unit
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package alct_pkg;

    // field widths fixed by the item formats
    localparam int TICK_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int CTR_IDX_W  = 1;
    localparam int ALARM_W    = 3;
    localparam int MAP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // counters and default alarm count
    localparam int NUM_CTR        = 2;
    localparam int NUM_ALARMS_DEF = 8;

    // remainder unit: one quotient bit per step over the tick+1 value
    localparam int DIV_STEPS = TICK_W + 1;

    // function codes of an input beat
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOD0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP  = 2'd2;

    // reset value of both moduli
    localparam logic [TICK_W-1:0] MOD_RESET = 16'hFFFF;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [CTR_IDX_W-1:0] counter_index;
        logic [ALARM_W-1:0]   alarm_index;
        logic [TICK_W-1:0]    start_ticks;
        logic [TICK_W-1:0]    cycle_ticks;
    } t_in_item;

    typedef struct packed {
        logic [TICK_W-1:0]  counter_value;
        logic               fired;
        logic [ALARM_W-1:0] expired_alarm;
        logic               last;
    } t_out_item;

    // arm / cancel command into one alarm cell
    typedef struct packed {
        logic              arm;
        logic              cancel;
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] cycle;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* sv/alct_in_if.sv */
// alct_in_if: valid/ready channel carrying one input beat
// depends on alct_pkg for the payload type
`default_nettype none

interface alct_in_if;
    import alct_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/alct_out_if.sv */
// alct_out_if: valid/ready channel carrying one result beat
// depends on alct_pkg for the payload type
`default_nettype none

interface alct_out_if;
    import alct_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/alarm_counter_tick_unit.sv */
// alarm_counter_tick_unit: top level, counters, walk sequencer and result register
// depends on alct_pkg, alct_in_if, alct_out_if, alct_cell and alct_rem
`default_nettype none

// Two tick counters and a chain of NUM_ALARMS alarm cells. One input beat is
// worked on at a time. A tick beat advances its counter, then a token walks
// the cell chain one cell per cycle while no result stalls, lowest alarm
// first; every enabled alarm bound to the ticked counter counts down as the
// token passes and an expiry yields one result beat, and a final result
// closes the tick (accept, token launch, the walk over every cell, final result). If
// the counter sits at or above a lowered modulus the wrap goes through a
// bit-serial remainder unit first. Arm, cancel and unused codes return one
// result. A stalled result holds the walk. The user must write moduli and
// the alarm map through the config port only while idle; the block does not
// enforce this, and there is no clearing pass after reset.
module alarm_counter_tick_unit #(
    parameter int NUM_ALARMS = alct_pkg::NUM_ALARMS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    alct_in_if.sink                              i_item,
    alct_out_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [alct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [alct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import alct_pkg::*;

    localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int XW = AW + ALARM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_FIN,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [TICK_W-1:0]   r_mod0;
    logic [TICK_W-1:0]   r_mod1;
    logic [MAP_W-1:0]    r_map;
    logic [TICK_W-1:0]   r_time [NUM_CTR];
    logic [CTR_IDX_W-1:0] r_cidx;
    logic                r_launch;
    logic                r_hold_v;
    logic [AW-1:0]       r_hold_a;
    logic                r_out_v;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_slot_free;
    logic                w_go;
    logic                w_emit;
    logic                w_is_tick;
    logic [TICK_W-1:0]   w_mod;
    logic [TICK_W-1:0]   w_cur;
    logic [TICK_W:0]     w_tp1;
    logic                w_fast;
    logic [TICK_W-1:0]   w_fast_val;
    logic                w_div_start;
    logic                w_div_done;
    logic [TICK_W-1:0]   w_div_rem;
    logic [NUM_ALARMS:0] w_tok;
    logic [NUM_ALARMS-1:0] w_fire;
    logic [NUM_ALARMS-1:0] w_bound;
    logic                w_fire_any;
    logic [AW-1:0]       w_fire_idx;
    logic [XW-1:0]       w_hold_x;
    logic [TICK_W-1:0]   w_time_sel;
    t_cell_cmd           w_cmd [NUM_ALARMS];

    // handshake
    assign w_accept      = i_item.valid & i_item.ready;
    assign i_item.ready  = (r_state == S_IDLE);
    assign w_slot_free   = !r_out_v | o_res.ready;
    assign w_go          = (r_state == S_WALK) & w_slot_free;
    assign o_res.valid   = r_out_v;
    assign o_res.data    = r_out;
    assign w_is_tick     = (i_item.data.func == FUNC_TICK);

    // a result beat is loaded into the output register this cycle
    assign w_emit = (w_go & w_fire_any & r_hold_v) |
                    (((r_state == S_FIN) | (r_state == S_RESP)) & w_slot_free);

    // counter advance: add one, wrap by compare or by the remainder unit
    always_comb begin
        w_mod      = (i_item.data.counter_index == 1'b1) ? r_mod1 : r_mod0;
        w_cur      = r_time[i_item.data.counter_index];
        w_tp1      = {1'b0, w_cur} + 1'b1;
        w_fast     = (w_mod == '0) || (w_tp1 <= {1'b0, w_mod});
        w_fast_val = (w_tp1 == {1'b0, w_mod}) ? '0 : w_tp1[TICK_W-1:0];
    end

    assign w_div_start = w_accept & w_is_tick & !w_fast;

    alct_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_tp1),
        .i_divisor  (w_mod),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // alarm cell chain
    assign w_tok[0] = r_launch;

    for (genvar a = 0; a < NUM_ALARMS; a++) begin : g_cell
        // alarms past the map are bound to counter zero
        if (a < MAP_W) begin : g_map
            assign w_bound[a] = (r_map[a] == r_cidx);
        end else begin : g_nomap
            assign w_bound[a] = (r_cidx == '0);
        end

        always_comb begin
            w_cmd[a].arm    = w_accept && (i_item.data.func == FUNC_ARM) &&
                              ({{AW{1'b0}}, i_item.data.alarm_index} == XW'(a));
            w_cmd[a].cancel = w_accept && (i_item.data.func == FUNC_CANCEL) &&
                              ({{AW{1'b0}}, i_item.data.alarm_index} == XW'(a));
            w_cmd[a].start  = i_item.data.start_ticks;
            w_cmd[a].cycle  = i_item.data.cycle_ticks;
        end

        alct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (w_go),
            .i_tok   (w_tok[a]),
            .i_bound (w_bound[a]),
            .i_cmd   (w_cmd[a]),
            .o_tok   (w_tok[a+1]),
            .o_fire  (w_fire[a])
        );
    end

    // index of the firing cell, at most one holds the token
    always_comb begin
        w_fire_idx = '0;
        for (int a = 0; a < NUM_ALARMS; a++) begin
            if (w_fire[a]) begin
                w_fire_idx = w_fire_idx | AW'(a);
            end
        end
    end

    assign w_fire_any = |w_fire;
    assign w_hold_x   = {{ALARM_W{1'b0}}, r_hold_a};
    assign w_time_sel = r_time[r_cidx];

    // sequencer, counters, config and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mod0   <= MOD_RESET;
            r_mod1   <= MOD_RESET;
            r_map    <= '0;
            for (int c = 0; c < NUM_CTR; c++) begin
                r_time[c] <= '0;
            end
            r_cidx   <= '0;
            r_launch <= 1'b0;
            r_hold_v <= 1'b0;
            r_hold_a <= '0;
            r_out_v  <= 1'b0;
            r_out    <= '0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MOD0: r_mod0 <= i_cfg_data[TICK_W-1:0];
                    CFG_MOD1: r_mod1 <= i_cfg_data[TICK_W-1:0];
                    CFG_MAP:  r_map  <= i_cfg_data[MAP_W-1:0];
                    default: ;
                endcase
            end

            if (o_res.ready && !w_emit) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cidx <= i_item.data.counter_index;
                        if (!w_is_tick) begin
                            r_state <= S_RESP;
                        end else if (w_fast) begin
                            r_time[i_item.data.counter_index] <= w_fast_val;
                            r_launch <= 1'b1;
                            r_state  <= S_WALK;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_time[r_cidx] <= w_div_rem;
                        r_launch <= 1'b1;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_go) begin
                        r_launch <= 1'b0;
                        // an earlier expiry goes out once a later one is seen
                        if (w_fire_any) begin
                            if (r_hold_v) begin
                                r_out_v <= 1'b1;
                                r_out   <= '{counter_value: w_time_sel, fired: 1'b1,
                                             expired_alarm: w_hold_x[ALARM_W-1:0],
                                             last: 1'b0};
                            end
                            r_hold_v <= 1'b1;
                            r_hold_a <= w_fire_idx;
                        end
                        if (w_tok[NUM_ALARMS]) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out_v  <= 1'b1;
                        r_out    <= '{counter_value: w_time_sel, fired: r_hold_v,
                                      expired_alarm: r_hold_v ? w_hold_x[ALARM_W-1:0] : '0,
                                      last: 1'b1};
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (w_slot_free) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{counter_value: w_time_sel, fired: 1'b0,
                                     expired_alarm: '0, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a single token walks the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok, 1'b0}))
        else $error("more than one walk token in the alarm chain");

    // expiries are reported one cell at a time
    a_one_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_fire))
        else $error("several alarm cells fire in the same cycle");

    // no held expiry survives the end of a tick
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held expiry left over while idle");

    // a walk ends with exactly one final result
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_slot_free) |=> (r_out_v && r_out.last))
        else $error("tick walk ended without a final result");

endmodule

`default_nettype wire

/* sv/alct_rem.sv */
// alct_rem: restoring remainder unit, one dividend bit per cycle
// depends on alct_pkg for widths; used to wrap a counter left above its modulus
`default_nettype none

module alct_rem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [alct_pkg::TICK_W:0]   i_dividend,
    input  wire logic [alct_pkg::TICK_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [alct_pkg::TICK_W-1:0]      o_rem
);
    import alct_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [TICK_W:0]   r_num;
    logic [TICK_W-1:0] r_div;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] n_rem;
    logic [TICK_W:0]   w_trial;
    logic [TICK_W:0]   w_sub;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_num[TICK_W]};
        w_sub   = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_sub[TICK_W-1:0];
        end else begin
            n_rem = w_trial[TICK_W-1:0];
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_num  <= {r_num[TICK_W-1:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == CW'(DIV_STEPS - 1));
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* sv/alct_cell.sv */
// alct_cell: one alarm of the chain, holding its countdown, reload and enable
// depends on alct_pkg; a walk token enters from the lower neighbor and leaves upward
`default_nettype none

module alct_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic                 i_tok,
    input  wire logic                 i_bound,
    input  wire alct_pkg::t_cell_cmd  i_cmd,
    output logic                      o_tok,
    output logic                      o_fire
);
    import alct_pkg::*;

    logic              r_tok;
    logic              r_en;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_reload;
    logic              w_visit;
    logic              w_zero;

    // this alarm counts only while the token sits here
    assign w_visit = i_go & r_tok & r_en & i_bound;
    assign w_zero  = (r_rem == TICK_W'(1));
    assign o_fire  = r_tok & r_en & i_bound & w_zero;
    assign o_tok   = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_en     <= 1'b0;
            r_rem    <= '0;
            r_reload <= '0;
        end else begin
            if (i_go) begin
                r_tok <= i_tok;
            end
            // arm only an idle alarm, zero start counts as one tick
            if (i_cmd.arm && !r_en) begin
                r_rem    <= (i_cmd.start == '0) ? TICK_W'(1) : i_cmd.start;
                r_reload <= i_cmd.cycle;
                r_en     <= 1'b1;
            end else if (i_cmd.cancel) begin
                r_en <= 1'b0;
            end else if (w_visit) begin
                // expiry reloads the cycle, a zero cycle stops the alarm
                if (w_zero) begin
                    r_rem <= r_reload;
                    if (r_reload == '0) begin
                        r_en <= 1'b0;
                    end
                end else begin
                    r_rem <= r_rem - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
